/* hw/rtl/tcs_pkg.sv */
package tcs_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } state_t;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_BACK = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // what one put or backspace does besides moving the cursor
    typedef struct packed {
        logic wr_cell;
        logic wr_blank;
        logic scroll;
    } step_ctl_t;

    localparam logic [15:0] BLANK_CELL   = 16'h0020;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  ATTR_RESET   = 8'h0F;

endpackage

/* hw/rtl/tcs_cursor.sv */
module tcs_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    localparam int ROW_W = $clog2(ROWS),
    localparam int COL_W = $clog2(COLUMNS)
) (
    input  logic [1:0]          op,
    input  logic [7:0]          char_code,
    input  logic [ROW_W-1:0]    row,
    input  logic [COL_W-1:0]    col,
    output logic [ROW_W-1:0]    step_row,
    output logic [COL_W-1:0]    step_col,
    output tcs_pkg::step_ctl_t  ctl
);

    logic last_row;
    logic last_col;

    assign last_row = (row == ROW_W'(ROWS - 1));
    assign last_col = (col == COL_W'(COLUMNS - 1));

    always_comb
    begin
        step_row = row;
        step_col = col;
        ctl      = '0;
        case (op)
            tcs_pkg::OP_PUT:
            begin
                if (char_code == tcs_pkg::NEWLINE_CODE)
                begin
                    step_col = '0;
                    if (last_row)
                        ctl.scroll = 1'b1;
                    else
                        step_row = row + 1'b1;
                end
                else
                begin
                    ctl.wr_cell = 1'b1;
                    if (last_col)
                    begin
                        step_col = '0;
                        if (last_row)
                            ctl.scroll = 1'b1;
                        else
                            step_row = row + 1'b1;
                    end
                    else
                    begin
                        step_col = col + 1'b1;
                    end
                end
            end
            tcs_pkg::OP_BACK:
            begin
                if (col != '0)
                begin
                    step_col     = col - 1'b1;
                    ctl.wr_blank = 1'b1;
                end
                else if (row != '0)
                begin
                    // wrap back to the end of the previous row
                    step_row     = row - 1'b1;
                    step_col     = COL_W'(COLUMNS - 1);
                    ctl.wr_blank = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* hw/rtl/text_console_cursor_scroll_top.sv */
// channel   | direction | signals                                   | handshake
// ----------+-----------+-------------------------------------------+------------------------
// command   | in        | op, char_code, read_row, read_col         | start while busy low
// result    | out       | cursor_row, cursor_col, cell_value        | done, one cycle, no stall
// config    | in        | cfg_wdata                                 | cfg_we
//
// put, newline and backspace that do not scroll raise done from the done register; a read
// passes the registered ram read data to the result register. a scroll moves the
// top-row pointer and then blanks the new bottom row, one cell per cycle through the
// single ram write port. after reset the ram is swept to zero with busy high; config
// writes are taken during the sweep. results cannot be stalled; done marks each one.
module text_console_cursor_scroll_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25,
    localparam int ROW_W = $clog2(ROWS),
    localparam int COL_W = $clog2(COLUMNS),
    localparam int TOTAL = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(TOTAL)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [7:0]        char_code,
    input  logic [ROW_W-1:0]  read_row,
    input  logic [COL_W-1:0]  read_col,
    output logic              done,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic [15:0]       cell_value,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata
);

    tcs_pkg::state_t     state_reg, state_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ROW_W-1:0]    crow_reg, crow_next;
    logic [COL_W-1:0]    ccol_reg, ccol_next;
    logic [7:0]          attr_reg, attr_next;
    logic [ADDR_W-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [COL_W-1:0]    sweep_col_reg, sweep_col_next;
    logic                done_reg, done_next;
    logic [15:0]         cell_reg, cell_next;
    logic [15:0]         rd_data_reg;

    logic [15:0]         mem [TOTAL];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [15:0]         mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                accept;
    logic                read_ok;
    logic                sweep_last;
    logic                scroll_last;
    logic [ROW_W-1:0]    step_row;
    logic [COL_W-1:0]    step_col;
    tcs_pkg::step_ctl_t  step_ctl;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   back_addr;
    logic [ADDR_W-1:0]   top_base;

    // logical row to ram row through the circular top-row pointer
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (ROW_W + 1)'(ROWS))
            sum = sum - (ROW_W + 1)'(ROWS);
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    tcs_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .op        (op),
        .char_code (char_code),
        .row       (crow_reg),
        .col       (ccol_reg),
        .step_row  (step_row),
        .step_col  (step_col),
        .ctl       (step_ctl)
    );

    assign busy        = (state_reg != tcs_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign read_ok     = ({1'b0, read_row} < (ROW_W + 1)'(ROWS))
                      && ({1'b0, read_col} < (COL_W + 1)'(COLUMNS));
    assign sweep_last  = (sweep_addr_reg == ADDR_W'(TOTAL - 1));
    assign scroll_last = (sweep_col_reg == COL_W'(COLUMNS - 1));
    assign cur_addr    = cell_addr(phys_row(crow_reg, top_reg), ccol_reg);
    assign back_addr   = cell_addr(phys_row(step_row, top_reg), step_col);
    assign top_base    = cell_addr(top_reg, '0);
    assign mem_raddr   = cell_addr(phys_row(read_row, top_reg), read_col);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcs_pkg::ST_CLEAR:
            begin
                if (sweep_last)
                    state_next = tcs_pkg::ST_IDLE;
            end
            tcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == tcs_pkg::OP_READ && read_ok)
                        state_next = tcs_pkg::ST_READ;
                    else if (step_ctl.scroll)
                        state_next = tcs_pkg::ST_SCROLL;
                end
            end
            tcs_pkg::ST_READ:
            begin
                state_next = tcs_pkg::ST_IDLE;
            end
            tcs_pkg::ST_SCROLL:
            begin
                if (scroll_last)
                    state_next = tcs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        top_next        = top_reg;
        crow_next       = crow_reg;
        ccol_next       = ccol_reg;
        attr_next       = cfg_we ? cfg_wdata : attr_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_col_next  = sweep_col_reg;
        done_next       = 1'b0;
        cell_next       = '0;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        case (state_reg)
            tcs_pkg::ST_CLEAR:
            begin
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + 1'b1;
            end
            tcs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    crow_next = step_row;
                    ccol_next = step_col;
                    if (step_ctl.wr_cell)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_addr;
                        mem_wdata = {attr_reg, char_code};
                    end
                    else if (step_ctl.wr_blank)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = back_addr;
                        mem_wdata = tcs_pkg::BLANK_CELL;
                    end
                    if (op == tcs_pkg::OP_READ && read_ok)
                    begin
                        mem_re = 1'b1;
                    end
                    else if (step_ctl.scroll)
                    begin
                        // old top row becomes the new bottom row
                        top_next        = (top_reg == ROW_W'(ROWS - 1)) ? '0
                                                                        : top_reg + 1'b1;
                        sweep_addr_next = top_base;
                        sweep_col_next  = '0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            tcs_pkg::ST_READ:
            begin
                done_next = 1'b1;
                cell_next = rd_data_reg;
            end
            tcs_pkg::ST_SCROLL:
            begin
                mem_we          = 1'b1;
                mem_wdata       = tcs_pkg::BLANK_CELL;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                sweep_col_next  = sweep_col_reg + 1'b1;
                if (scroll_last)
                    done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tcs_pkg::ST_CLEAR;
            top_reg        <= '0;
            crow_reg       <= '0;
            ccol_reg       <= '0;
            attr_reg       <= tcs_pkg::ATTR_RESET;
            sweep_addr_reg <= '0;
            sweep_col_reg  <= '0;
            done_reg       <= 1'b0;
            cell_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            crow_reg       <= crow_next;
            ccol_reg       <= ccol_next;
            attr_reg       <= attr_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_col_reg  <= sweep_col_next;
            done_reg       <= done_next;
            cell_reg       <= cell_next;
        end
    end

    // cell store, one write and one read port, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign done       = done_reg;
    assign cursor_row = crow_reg;
    assign cursor_col = ccol_reg;
    assign cell_value = cell_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, crow_reg} < (ROW_W + 1)'(ROWS)) && ({1'b0, ccol_reg} < (COL_W + 1)'(COLUMNS)))
        else $error("cursor outside the screen");

    a_scroll_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcs_pkg::ST_SCROLL && scroll_last)
        |=> (done_reg && crow_reg == ROW_W'(ROWS - 1) && ccol_reg == '0))
        else $error("scroll did not finish at start of last row");

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("ram read and write in one cycle");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (state_reg == tcs_pkg::ST_READ) ##1 done_reg)
        else $error("read transaction lost its result");

endmodule
